>>> rtl/core/fir160_pkg.sv
// Shared constants, codes and types for the 160-tap FIR filter core.
`default_nettype none

package fir160_pkg;

  // Default number of taps in the delay line and coefficient memory
  localparam int TAPS_DEF = 160;

  // Sample and coefficient word width
  localparam int DATA_W = 16;

  // Fraction-bit register
  localparam int          FRAC_W     = 5;
  localparam logic [4:0]  FRAC_RESET = 5'd15;

  // Input word packing (tdata): coef_index, coef_value, sample_in
  localparam int IDX_W   = 8;
  localparam int S_TDATA_W = IDX_W + 2 * DATA_W;
  localparam int M_TDATA_W = DATA_W;

  // Operation codes carried in tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ABS,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/fir160_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fir160_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 160,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/fir_filter_160_tap_core.sv
// Direct-form FIR filter core: one shared multiply-accumulate unit over TAPS taps.
// Sample word: keeps the core busy for one MAC per tap, set by the single read port of
//   the delay and coefficient memories; then the sum is shifted, saturated and loaded
//   into the output register, which waits while a previous result is stalled.
// Coefficient word: written in the accept cycle if coef_index < TAPS, ready again the next cycle, no result.
// Reset (rst, synchronous): output valid cleared, then a clearing pass zeroes both
//   memories while s_tready stays low; configuration writes are taken during the pass.
`default_nettype none

module fir_filter_160_tap_core
  import fir160_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration: frac_bits
  input  wire logic                 cfg_wr_en,
  input  wire logic [FRAC_W-1:0]    cfg_wr_data,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // coef_index[7:0], coef_value[23:8], sample_in[39:24]
  input  wire logic                 s_tuser,   // op
  // output stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata    // sample_out[15:0]
);

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W = PROD_W + 1 + $clog2(TAPS);
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  state_t state, state_next;

  logic [FRAC_W-1:0] frac_bits;
  logic [AW-1:0]     clr_cnt;
  logic [AW-1:0]     head;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     tap;
  logic [AW-1:0]     ptr;
  logic              rd_vld;
  logic              prod_vld;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  mag;
  logic              neg;
  logic [ACC_W-1:0]  quo;
  logic [DATA_W-1:0] sat;

  // input word fields
  logic [IDX_W-1:0]  coef_index;
  logic [DATA_W-1:0] coef_value;
  logic [DATA_W-1:0] sample_in;
  logic              accept;
  logic              acc_sample;
  logic              acc_coef;
  logic              idx_ok;

  // memory ports
  logic              c_we,  d_we;
  logic [AW-1:0]     c_waddr, d_waddr;
  logic [DATA_W-1:0] c_wdata, d_wdata;
  logic [DATA_W-1:0] c_q, d_q;

  // sequencer outputs
  logic              issue;
  logic              out_load;

  assign coef_index = s_tdata[IDX_W-1:0];
  assign coef_value = s_tdata[IDX_W+DATA_W-1:IDX_W];
  assign sample_in  = s_tdata[S_TDATA_W-1:IDX_W+DATA_W];

  assign accept     = s_tvalid && s_tready;
  assign acc_sample = accept && (s_tuser == OP_SAMPLE);
  assign acc_coef   = accept && (s_tuser == OP_COEF);
  assign idx_ok     = (32'(coef_index) < TAPS);
  assign head_inc   = (head == LAST) ? '0 : head + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == LAST) state_next = S_IDLE;
      S_IDLE:  if (acc_sample) state_next = S_MAC;
      S_MAC:   if (tap == LAST) state_next = S_DRAIN;
      S_DRAIN: if (!rd_vld && !prod_vld) state_next = S_ABS;
      S_ABS:   state_next = S_OUT;
      S_OUT:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // sequencer outputs and memory write ports
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    c_we     = 1'b0;
    c_waddr  = clr_cnt;
    c_wdata  = '0;
    d_we     = 1'b0;
    d_waddr  = clr_cnt;
    d_wdata  = '0;
    case (state)
      S_CLEAR: begin
        c_we = 1'b1;
        d_we = 1'b1;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        c_we     = acc_coef && idx_ok;
        c_waddr  = AW'(coef_index);
        c_wdata  = coef_value;
        d_we     = acc_sample;
        d_waddr  = head_inc;
        d_wdata  = sample_in;
      end
      S_MAC:   issue = 1'b1;
      S_DRAIN: ;
      S_ABS:   ;
      S_OUT:   out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      frac_bits <= FRAC_RESET;
      clr_cnt   <= '0;
      head      <= '0;
      rd_vld    <= 1'b0;
      prod_vld  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= issue;
      prod_vld <= rd_vld;
      if (cfg_wr_en) begin
        frac_bits <= cfg_wr_data;
      end
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (acc_sample) begin
        head <= head_inc;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // tap walk: coefficient index up, delay pointer back from the newest sample
  always_ff @(posedge clk) begin
    if (acc_sample) begin
      tap <= '0;
      ptr <= head_inc;
    end else if (issue) begin
      tap <= tap + 1'b1;
      ptr <= (ptr == '0) ? LAST : ptr - 1'b1;
    end
  end

  // shared multiply-accumulate
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= $signed(c_q) * $signed(d_q);
    end
    if (acc_sample) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // magnitude for truncation toward zero
  always_ff @(posedge clk) begin
    if (state == S_ABS) begin
      neg <= acc[ACC_W-1];
      mag <= acc[ACC_W-1] ? $unsigned(-acc) : $unsigned(acc);
    end
  end

  // shift and saturate
  always_comb begin
    quo = mag >> frac_bits;
    if (neg) begin
      if (quo > ACC_W'(32768)) sat = 16'h8000;
      else                     sat = DATA_W'(-quo);
    end else begin
      if (quo > ACC_W'(32767)) sat = 16'h7fff;
      else                     sat = quo[DATA_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= sat;
    end
  end

  fir160_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (tap),
    .rdata (c_q)
  );

  fir160_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TAPS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (ptr),
    .rdata (d_q)
  );

endmodule

`default_nettype wire

>>> rtl/core/fir160_checker.sv
// Port-level checks for the FIR filter core, bound to fir_filter_160_tap_core.
`default_nettype none

module fir160_checker
  import fir160_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // a sample word keeps the core busy
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_SAMPLE) |=> !s_tready)
    else $error("core ready right after a sample word");

  // a coefficient word leaves the core ready
  a_coef_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_COEF) |=> s_tready)
    else $error("core busy after a coefficient word");

  // a new result only comes out of a busy stretch
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a computation");

endmodule

bind fir_filter_160_tap_core fir160_checker u_chk (.*);

`default_nettype wire
